// ===== rtl/signal_pending_queue_engine_assert.svh =====
// Assertion macros used by the checker file
`ifndef SIGNAL_PENDING_QUEUE_ENGINE_ASSERT_SVH
`define SIGNAL_PENDING_QUEUE_ENGINE_ASSERT_SVH

// implication checked on the same edge
`define SPQ_ASSERT_IMP(label, clk, rstn, a, c) \
	label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
		else $error("spq check failed");

// implication checked on the following edge
`define SPQ_ASSERT_NEXT(label, clk, rstn, a, c) \
	label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
		else $error("spq check failed");

`endif

// ===== rtl/spq_pkg.sv =====
// Shared codes and widths for the signal pending queue engine
`default_nettype none
package spq_pkg;
	localparam int OP_W   = 2;
	localparam int SIG_W  = 7;
	localparam int IDX_W  = 6;
	localparam int PAY_W  = 32;
	localparam int MASK_W = 64;

	localparam logic [OP_W-1:0] OP_APP_THREAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_APP_PROCESS = 2'd1;
	localparam logic [OP_W-1:0] OP_POP         = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY       = 2'd3;

	typedef struct packed {
		logic             app;
		logic             pop;
		logic [IDX_W-1:0] idx;
	} spq_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/signal_pending_queue_engine.sv =====
// Top level: two signal queues with pop arbitration and result register
// An accepted item's row (ring head/fill and payloads) is registered; in ST_READ
// the row is written back and the result register is loaded. No new item is
// taken in ST_READ or while a result waits on out_ready.
// Reset (arst_n low) clears both pending masks at once; a clear pending bit
// marks a slot or ring empty, so the row memories need no clearing pass.
`default_nettype none
module signal_pending_queue_engine #(
	parameter int SIGNAL_COUNT   = 64,
	parameter int FIRST_REALTIME = 32,
	parameter int RT_RING_DEPTH  = 4,
	parameter int PAYLOAD_BITS   = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [spq_pkg::OP_W-1:0]   op,
	input  wire logic [spq_pkg::SIG_W-1:0]  signal_number,
	input  wire logic [spq_pkg::PAY_W-1:0]  payload,
	input  wire logic [spq_pkg::MASK_W-1:0] block_mask,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            accepted,
	output logic                            found,
	output logic [spq_pkg::SIG_W-1:0]       popped_number,
	output logic [spq_pkg::PAY_W-1:0]       popped_payload,
	output logic                            from_process,
	output logic [spq_pkg::MASK_W-1:0]      thread_pending_bits,
	output logic [spq_pkg::MASK_W-1:0]      process_pending_bits,
	output logic                            unblocked_pending
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic take;

	spq_pkg::spq_cmd_t       cmd_t, cmd_p;
	logic                    ok_t, ok_p;
	logic [SIGNAL_COUNT-1:0] mask_t, mask_p, mask_nx_t, mask_nx_p, cand;
	logic [PAYLOAD_BITS-1:0] pay_w, rd_t, rd_p;
	logic [spq_pkg::IDX_W-1:0] idx, low_idx;
	logic sig_ok, any_cand, low_from_p, is_pop;

	// item stage held across the memory read
	logic                    found_s1, fromp_s1;
	logic [spq_pkg::SIG_W-1:0] num_s1;
	logic [SIGNAL_COUNT-1:0] block_s1;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid || out_ready);
	assign take     = in_valid && in_ready;

	assign idx    = spq_pkg::IDX_W'(signal_number - spq_pkg::SIG_W'(1));
	assign sig_ok = (signal_number != '0) && (int'(signal_number) <= SIGNAL_COUNT);
	assign pay_w  = PAYLOAD_BITS'(payload);
	assign cand   = (mask_t | mask_p) & ~block_mask[SIGNAL_COUNT-1:0];
	assign is_pop = take && (op == spq_pkg::OP_POP);

	// lowest unblocked pending signal; thread wins when both hold it
	always_comb begin
		low_idx = '0;
		for (int i = SIGNAL_COUNT - 1; i >= 0; i--) begin
			if (cand[i]) low_idx = spq_pkg::IDX_W'(i);
		end
		any_cand   = |cand;
		low_from_p = !mask_t[low_idx];
	end

	always_comb begin
		cmd_t.app = take && (op == spq_pkg::OP_APP_THREAD) && sig_ok;
		cmd_p.app = take && (op == spq_pkg::OP_APP_PROCESS) && sig_ok;
		cmd_t.pop = is_pop && any_cand && !low_from_p;
		cmd_p.pop = is_pop && any_cand && low_from_p;
		cmd_t.idx = is_pop ? low_idx : idx;
		cmd_p.idx = is_pop ? low_idx : idx;
	end

	spq_queue #(
		.SIGNAL_COUNT(SIGNAL_COUNT), .FIRST_REALTIME(FIRST_REALTIME),
		.RT_RING_DEPTH(RT_RING_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_thread (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_t), .wr_pay(pay_w),
		.app_ok(ok_t), .mask(mask_t), .mask_nx(mask_nx_t), .rd_pay(rd_t)
	);

	spq_queue #(
		.SIGNAL_COUNT(SIGNAL_COUNT), .FIRST_REALTIME(FIRST_REALTIME),
		.RT_RING_DEPTH(RT_RING_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_process (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_p), .wr_pay(pay_w),
		.app_ok(ok_p), .mask(mask_p), .mask_nx(mask_nx_p), .rd_pay(rd_p)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			found_s1 <= is_pop && any_cand;
			fromp_s1 <= is_pop && any_cand && low_from_p;
			num_s1   <= (is_pop && any_cand) ?
				spq_pkg::SIG_W'(low_idx) + spq_pkg::SIG_W'(1) : '0;
			block_s1 <= block_mask[SIGNAL_COUNT-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid && out_ready) out_valid <= 1'b0;
					if (take) state_q <= ST_READ;
				end
				ST_READ: begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register, loaded in the write-back cycle with the masks after the step
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			accepted      <= ok_t || ok_p;
			found         <= found_s1;
			popped_number <= num_s1;
			from_process  <= fromp_s1;
			popped_payload <= !found_s1 ? '0 :
				(fromp_s1 ? spq_pkg::PAY_W'(rd_p) : spq_pkg::PAY_W'(rd_t));
			thread_pending_bits  <= spq_pkg::MASK_W'(mask_nx_t);
			process_pending_bits <= spq_pkg::MASK_W'(mask_nx_p);
			unblocked_pending    <= |((mask_nx_t | mask_nx_p) & ~block_s1);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/spq_queue.sv =====
// One signal queue: row memory (ring head/fill plus payloads) and pending mask
`default_nettype none
module spq_queue #(
	parameter int SIGNAL_COUNT   = 64,
	parameter int FIRST_REALTIME = 32,
	parameter int RT_RING_DEPTH  = 4,
	parameter int PAYLOAD_BITS   = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire spq_pkg::spq_cmd_t       cmd,
	input  wire logic [PAYLOAD_BITS-1:0] wr_pay,
	output logic                         app_ok,
	output logic [SIGNAL_COUNT-1:0]      mask,
	output logic [SIGNAL_COUNT-1:0]      mask_nx,
	output logic [PAYLOAD_BITS-1:0]      rd_pay
);
	localparam int D    = RT_RING_DEPTH;
	localparam int HW   = (D > 1) ? $clog2(D) : 1;
	localparam int FW   = $clog2(D + 1);

	// one row per signal; standard signals use lane 0 only
	typedef struct packed {
		logic [HW-1:0]                  head;
		logic [FW-1:0]                  fill;
		logic [D-1:0][PAYLOAD_BITS-1:0] lane;
	} row_t;

	row_t                    mem [SIGNAL_COUNT];
	row_t                    row_s1, row_nx;
	spq_pkg::spq_cmd_t       cmd_s1;
	logic [PAYLOAD_BITS-1:0] pay_s1;
	logic [SIGNAL_COUNT-1:0] mask_q;

	logic          is_rt, occ, full, wr_en;
	logic [HW-1:0] head_c, head_nx, wslot, rslot;
	logic [FW-1:0] fill_c;
	logic [FW:0]   wsum;
	logic [HW:0]   hinc;

	assign is_rt  = int'(cmd_s1.idx) >= FIRST_REALTIME - 1;
	assign occ    = mask_q[cmd_s1.idx];
	// clear pending bit: ring is empty whatever the row still holds
	assign head_c = occ ? row_s1.head : '0;
	assign fill_c = occ ? row_s1.fill : '0;

	always_comb begin
		wsum = (FW+1)'(head_c) + (FW+1)'(fill_c);
		if (int'(wsum) >= D) begin
			wsum = wsum - (FW+1)'(D);
		end
		wslot   = is_rt ? HW'(wsum) : '0;
		rslot   = is_rt ? head_c : '0;
		hinc    = (HW+1)'(head_c) + (HW+1)'(1);
		head_nx = (int'(hinc) >= D) ? '0 : HW'(hinc);
		full    = is_rt ? (int'(fill_c) == D) : occ;
		app_ok  = cmd_s1.app && !full;
		wr_en   = app_ok || cmd_s1.pop;
		rd_pay  = row_s1.lane[rslot];
		row_nx  = row_s1;
		mask_nx = mask_q;
		if (app_ok) begin
			row_nx.lane[wslot] = pay_s1;
			row_nx.head        = head_c;
			row_nx.fill        = is_rt ? fill_c + FW'(1) : fill_c;
			mask_nx[cmd_s1.idx] = 1'b1;
		end else if (cmd_s1.pop) begin
			if (is_rt) begin
				row_nx.head = head_nx;
				row_nx.fill = fill_c - FW'(1);
				if (fill_c == FW'(1)) mask_nx[cmd_s1.idx] = 1'b0;
			end else begin
				mask_nx[cmd_s1.idx] = 1'b0;
			end
		end
	end

	assign mask = mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			cmd_s1 <= '0;
		end else begin
			mask_q <= mask_nx;
			cmd_s1 <= cmd;
		end
	end

	// row memory: registered read, write-back in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.app || cmd.pop) begin
			row_s1 <= mem[cmd.idx];
			pay_s1 <= wr_pay;
		end
		if (wr_en) mem[cmd_s1.idx] <= row_nx;
	end
endmodule
`default_nettype wire

// ===== rtl/spq_checker.sv =====
// Port-level checks for the signal pending queue engine
`default_nettype none
`include "signal_pending_queue_engine_assert.svh"
module spq_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic                            accepted,
	input wire logic                            found,
	input wire logic                            from_process,
	input wire logic [spq_pkg::SIG_W-1:0]       popped_number
);
	`SPQ_ASSERT_IMP(a_found_num, clk, arst_n, out_valid && found, popped_number != '0)
	`SPQ_ASSERT_IMP(a_none_zero, clk, arst_n, out_valid && !found, popped_number == '0 && !from_process)
	`SPQ_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !(accepted && found))
	`SPQ_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	`SPQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind signal_pending_queue_engine spq_checker u_spq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
	.found(found), .from_process(from_process), .popped_number(popped_number)
);
`default_nettype wire

// ===== dv/signal_pending_queue_engine_tb.sv =====
// Testbench for the signal pending queue engine: random and directed items checked against a predictor
`timescale 1ns / 100ps
`default_nettype none

// Holds the predicted queue state and the results still owed by the block
class sigq_scoreboard;
	typedef struct packed {
		logic        accepted;
		logic        found;
		logic [6:0]  popped_number;
		logic [31:0] popped_payload;
		logic        from_process;
		logic [63:0] thread_pending_bits;
		logic [63:0] process_pending_bits;
		logic        unblocked_pending;
	} sig_result_t;

	// index 0 thread, 1 process; signals 1..64
	bit          std_busy [2][65];
	bit [31:0]   std_pay  [2][65];
	bit [31:0]   ring     [2][65][4];
	int unsigned ring_head[2][65];
	int unsigned ring_fill[2][65];
	bit [63:0]   pend     [2];
	sig_result_t owed[$];
	int          errors;

	function bit store_sig(int q, int sig, bit [31:0] pay);
		if (sig < 1 || sig > 64)
			return 0;
		if (sig < 32) begin
			if (std_busy[q][sig])
				return 0;
			std_busy[q][sig] = 1;
			std_pay[q][sig] = pay;
		end else begin
			if (ring_fill[q][sig] >= 4)
				return 0;
			ring[q][sig][(ring_head[q][sig] + ring_fill[q][sig]) % 4] = pay;
			ring_fill[q][sig]++;
		end
		pend[q][sig-1] = 1'b1;
		return 1;
	endfunction

	function bit take_sig(int q, int sig, output bit [31:0] pay);
		pay = '0;
		if (sig < 32) begin
			if (!std_busy[q][sig])
				return 0;
			pay = std_pay[q][sig];
			std_busy[q][sig] = 0;
			pend[q][sig-1] = 1'b0;
		end else begin
			if (ring_fill[q][sig] == 0)
				return 0;
			pay = ring[q][sig][ring_head[q][sig]];
			ring_head[q][sig] = (ring_head[q][sig] + 1) % 4;
			ring_fill[q][sig]--;
			if (ring_fill[q][sig] == 0)
				pend[q][sig-1] = 1'b0;
		end
		return 1;
	endfunction

	// note an accepted item and queue its predicted result
	function void note_item(logic [1:0] op, logic [6:0] sig, logic [31:0] pay,
			logic [63:0] blk);
		sig_result_t r;
		bit [31:0] v;
		r = '0;
		if (op == spq_pkg::OP_APP_THREAD)
			r.accepted = store_sig(0, sig, pay);
		else if (op == spq_pkg::OP_APP_PROCESS)
			r.accepted = store_sig(1, sig, pay);
		else if (op == spq_pkg::OP_POP) begin
			for (int s = 1; s <= 64; s++) begin
				if (blk[s-1])
					continue;
				if (take_sig(0, s, v))
					r.found = 1;
				else if (take_sig(1, s, v)) begin
					r.found = 1;
					r.from_process = 1;
				end
				if (r.found) begin
					r.popped_number = 7'(s);
					r.popped_payload = v;
					break;
				end
			end
		end
		r.thread_pending_bits = pend[0];
		r.process_pending_bits = pend[1];
		r.unblocked_pending = |((pend[0] | pend[1]) & ~blk);
		owed.push_back(r);
	endfunction

	function void check_result(sig_result_t got);
		sig_result_t exp;
		if (owed.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp = owed.pop_front();
		if (exp.accepted !== got.accepted)
			$display("%0t: accepted exp %h got %h", $time, exp.accepted, got.accepted);
		if (exp.found !== got.found)
			$display("%0t: found exp %h got %h", $time, exp.found, got.found);
		if (exp.popped_number !== got.popped_number)
			$display("%0t: popped_number exp %0d got %0d", $time,
				exp.popped_number, got.popped_number);
		if (exp.popped_payload !== got.popped_payload)
			$display("%0t: popped_payload exp %h got %h", $time,
				exp.popped_payload, got.popped_payload);
		if (exp.from_process !== got.from_process)
			$display("%0t: from_process exp %h got %h", $time,
				exp.from_process, got.from_process);
		if (exp.thread_pending_bits !== got.thread_pending_bits)
			$display("%0t: thread_pending_bits exp %h got %h", $time,
				exp.thread_pending_bits, got.thread_pending_bits);
		if (exp.process_pending_bits !== got.process_pending_bits)
			$display("%0t: process_pending_bits exp %h got %h", $time,
				exp.process_pending_bits, got.process_pending_bits);
		if (exp.unblocked_pending !== got.unblocked_pending)
			$display("%0t: unblocked_pending exp %h got %h", $time,
				exp.unblocked_pending, got.unblocked_pending);
		if (exp !== got)
			errors++;
	endfunction
endclass

module signal_pending_queue_engine_tb;
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [spq_pkg::OP_W-1:0]    op = spq_pkg::OP_QUERY;
	logic [spq_pkg::SIG_W-1:0]   signal_number = '0;
	logic [spq_pkg::PAY_W-1:0]   payload = '0;
	logic [spq_pkg::MASK_W-1:0]  block_mask = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        accepted;
	logic                        found;
	logic [spq_pkg::SIG_W-1:0]   popped_number;
	logic [spq_pkg::PAY_W-1:0]   popped_payload;
	logic                        from_process;
	logic [spq_pkg::MASK_W-1:0]  thread_pending_bits;
	logic [spq_pkg::MASK_W-1:0]  process_pending_bits;
	logic                        unblocked_pending;

	sigq_scoreboard sigq_model = new();
	bit             feed_done = 0;
	// both sides idle on random draws; toggles whole stretches with no idling
	bit             burst_mode = 0;

	signal_pending_queue_engine u_dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop: far above the time ~1300 items take with the largest gap and stall
	initial begin
		#400000;
		$display("signal_pending_queue_engine: mismatch");
		$finish;
	end

	// Apply one item and wait for the handshake; the predictor is updated at acceptance.
	// Valid drops only when a gap follows, so back-to-back items keep it high.
	task automatic send_item(logic [1:0] o, logic [6:0] s, logic [31:0] p, logic [63:0] b);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		signal_number <= s;
		payload <= p;
		block_mask <= b;
		do @(posedge clk); while (!in_ready);
		sigq_model.note_item(o, s, p, b);
	endtask

	// Random mask: mostly open, sometimes sparse, sometimes all set
	function automatic logic [63:0] pick_mask();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return '0;
		if (k < 7)
			return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		if (k < 9)
			return {$urandom, $urandom};
		return '1;
	endfunction

	// Favor a few hot signals so slots collide and rings fill up
	function automatic logic [6:0] pick_sig();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return $urandom_range(0, 127);
		if (k < 3)
			return (k == 1) ? 7'd1 : 7'd64;
		if (k < 12)
			return $urandom_range(28, 36);
		return $urandom_range(1, 64);
	endfunction

	// Result side: random stall per item, checks on every accepted result
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sigq_model.check_result({accepted, found, popped_number, popped_payload,
				from_process, thread_pending_bits, process_pending_bits,
				unblocked_pending});
		end
	end

	initial begin
		int k;
		logic [1:0] o;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop and query, bad numbers, field extremes
		send_item(spq_pkg::OP_POP, 7'd0, 32'h0, 64'h0);
		send_item(spq_pkg::OP_QUERY, 7'd0, 32'h0, 64'h0);
		send_item(spq_pkg::OP_APP_THREAD, 7'd0, 32'hFFFF_FFFF, 64'h0);
		send_item(spq_pkg::OP_APP_PROCESS, 7'd65, 32'h1, 64'h0);
		send_item(spq_pkg::OP_APP_THREAD, 7'd127, 32'h2, '1);
		send_item(spq_pkg::OP_APP_THREAD, 7'd1, 32'hFFFF_FFFF, 64'h0);
		send_item(spq_pkg::OP_APP_THREAD, 7'd1, 32'h1234_5678, 64'h0); // occupied slot
		send_item(spq_pkg::OP_APP_PROCESS, 7'd1, 32'hA5A5_5A5A, 64'h0);
		send_item(spq_pkg::OP_APP_THREAD, 7'd31, 32'h0, 64'h0);
		for (int i = 0; i < 5; i++) // fifth hits a full ring
			send_item(spq_pkg::OP_APP_PROCESS, 7'd64, 32'hC000_0000 + 32'(i), 64'h0);
		send_item(spq_pkg::OP_QUERY, 7'd0, 32'h0, '1);
		send_item(spq_pkg::OP_QUERY, 7'd0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFE);
		send_item(spq_pkg::OP_POP, 7'd0, 32'h0, '1);                 // all blocked
		send_item(spq_pkg::OP_POP, 7'd0, 32'h0, 64'h0);              // thread 1
		send_item(spq_pkg::OP_POP, 7'd0, 32'h0, 64'h0);              // process 1
		send_item(spq_pkg::OP_POP, 7'd0, 32'h0, 64'h0);              // thread 31
		for (int i = 0; i < 5; i++)
			send_item(spq_pkg::OP_POP, 7'd0, 32'h0, 64'h7FFF_FFFF_FFFF_FFFF);

		// random: appends (60%) outweigh pops (30%), with queries (10%) between
		for (int i = 0; i < 1250; i++) begin
			if ($urandom_range(0, 99) == 0)
				burst_mode = ~burst_mode;
			k = $urandom_range(0, 9);
			o = (k < 3) ? spq_pkg::OP_APP_THREAD : (k < 6) ? spq_pkg::OP_APP_PROCESS :
				(k < 9) ? spq_pkg::OP_POP : spq_pkg::OP_QUERY;
			send_item(o, pick_sig(), {$urandom_range(0, 1) ? 16'hFFFF : 16'h0,
				16'($urandom)} ^ $urandom, pick_mask());
		end
		in_valid <= 1'b0;
		burst_mode = 0;
		feed_done = 1;
	end

	initial begin
		wait (feed_done);
		while (sigq_model.owed.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sigq_model.errors == 0)
			$display("signal_pending_queue_engine: match");
		else
			$display("signal_pending_queue_engine: mismatch");
		$finish;
	end
endmodule

`default_nettype wire

// ===== signal_pending_queue_engine.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_queue.sv
rtl/signal_pending_queue_engine.sv
rtl/spq_checker.sv
dv/signal_pending_queue_engine_tb.sv
